// File: src/kfu_pkg.sv
// ---------------------------------------------------------------------------
// kfu_pkg
// Shared types, scratch memory map and microcode table for the Kalman
// filter update core.
// ---------------------------------------------------------------------------
package kfu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int NUM_CFG   = 5;
  localparam int DIV_STEPS = 15;

  typedef logic [5:0] addr_t;
  typedef logic [6:0] step_t;

  // Scratch memory map, four words per matrix, two per vector
  localparam addr_t AD_A    = 6'd0;
  localparam addr_t AD_B    = 6'd4;
  localparam addr_t AD_H    = 6'd8;
  localparam addr_t AD_Q    = 6'd12;
  localparam addr_t AD_R    = 6'd16;
  localparam addr_t AD_X    = 6'd20;
  localparam addr_t AD_P    = 6'd22;
  localparam addr_t AD_K    = 6'd26;
  localparam addr_t AD_U    = 6'd30;
  localparam addr_t AD_Z    = 6'd32;
  localparam addr_t AD_XP   = 6'd34;
  localparam addr_t AD_BU   = 6'd36;
  localparam addr_t AD_T1   = 6'd38;
  localparam addr_t AD_T2   = 6'd42;
  localparam addr_t AD_PP   = 6'd46;
  localparam addr_t AD_NUM  = 6'd50;
  localparam addr_t AD_S    = 6'd54;
  localparam addr_t AD_ONE  = 6'd62;
  localparam addr_t AD_ZERO = 6'd63;
  // Reused slots once their first contents are dead
  localparam addr_t AD_INV   = AD_T1;
  localparam addr_t AD_HX    = AD_BU;
  localparam addr_t AD_INNOV = AD_U;
  localparam addr_t AD_CORR  = AD_BU;
  localparam addr_t AD_KH    = AD_T2;
  localparam addr_t AD_IKH   = AD_T1;

  localparam logic [15:0] ONE_Q = 16'(1 << FRAC_BITS);
  localparam step_t STEP_LAST = 7'd66;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MAC,
    OP_ADD,
    OP_SUB,
    OP_DET,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t   op;
    addr_t dst;
    addr_t a0;
    addr_t b0;
    addr_t a1;
    addr_t b1;
    logic  neg;
  } uop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CFG,
    S_ISSUE,
    S_MUL0,
    S_MUL1,
    S_ACC,
    S_WB,
    S_DIVI,
    S_DIVS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       cfg_take;
    logic       in_take;
    logic       cfg_wr;
    logic       load;
    logic       rd_second;
    logic       mul;
    logic       acc_init;
    logic       acc_add;
    logic       wb;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic [3:0] cnt;
    uop_t       uop;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic out_free;
  } status_t;

  // Matrix product element e = 2i+j; tb selects a transposed right operand
  function automatic uop_t op_mm(addr_t dst, addr_t ma, addr_t mb, logic tb,
                                 logic [1:0] e);
    uop_t u;
    u.op  = OP_MAC;
    u.neg = 1'b0;
    u.dst = dst + {4'b0, e};
    u.a0  = ma + {4'b0, e[1], 1'b0};
    u.a1  = ma + {4'b0, e[1], 1'b1};
    if (tb) begin
      u.b0 = mb + {4'b0, e[0], 1'b0};
      u.b1 = mb + {4'b0, e[0], 1'b1};
    end else begin
      u.b0 = mb + {5'b0, e[0]};
      u.b1 = mb + {4'b0, 1'b1, e[0]};
    end
    return u;
  endfunction

  // Matrix times vector, element e
  function automatic uop_t op_mv(addr_t dst, addr_t ma, addr_t v, logic e);
    uop_t u;
    u.op  = OP_MAC;
    u.neg = 1'b0;
    u.dst = dst + {5'b0, e};
    u.a0  = ma + {4'b0, e, 1'b0};
    u.a1  = ma + {4'b0, e, 1'b1};
    u.b0  = v;
    u.b1  = v + 6'd1;
    return u;
  endfunction

  // Element-wise saturating add or subtract
  function automatic uop_t op_ew(op_t opc, addr_t dst, addr_t ma, addr_t mb,
                                 logic [1:0] e);
    uop_t u;
    u.op  = opc;
    u.neg = 1'b0;
    u.dst = dst + {4'b0, e};
    u.a0  = ma + {4'b0, e};
    u.b0  = mb + {4'b0, e};
    u.a1  = AD_ZERO;
    u.b1  = AD_ZERO;
    return u;
  endfunction

  // Microcode: one Kalman step as a list of word operations
  function automatic uop_t ucode(step_t s);
    uop_t       u;
    logic [1:0] k;
    logic       diag;
    u    = '0;
    k    = 2'(s - 7'd39);
    diag = (k == 2'd0) || (k == 2'd3);
    case (s) inside
      [7'd0:7'd3]: begin
        u.op  = OP_LOAD;
        u.dst = (s < 7'd2) ? AD_U + 6'(s) : AD_Z + 6'(s - 7'd2);
        u.a0  = 6'(s);
      end
      [7'd4:7'd5]:   u = op_mv(AD_XP, AD_A, AD_X, 1'(s - 7'd4));
      [7'd6:7'd7]:   u = op_mv(AD_BU, AD_B, AD_U, 1'(s - 7'd6));
      [7'd8:7'd9]:   u = op_ew(OP_ADD, AD_XP, AD_XP, AD_BU, 2'(s - 7'd8));
      [7'd10:7'd13]: u = op_mm(AD_T1, AD_A, AD_P, 1'b0, 2'(s - 7'd10));
      [7'd14:7'd17]: u = op_mm(AD_T2, AD_T1, AD_A, 1'b1, 2'(s - 7'd14));
      [7'd18:7'd21]: u = op_ew(OP_ADD, AD_PP, AD_Q, AD_T2, 2'(s - 7'd18));
      [7'd22:7'd25]: u = op_mm(AD_NUM, AD_PP, AD_H, 1'b1, 2'(s - 7'd22));
      [7'd26:7'd29]: u = op_mm(AD_T1, AD_H, AD_PP, 1'b0, 2'(s - 7'd26));
      [7'd30:7'd33]: u = op_mm(AD_T2, AD_T1, AD_H, 1'b1, 2'(s - 7'd30));
      [7'd34:7'd37]: u = op_ew(OP_ADD, AD_S, AD_T2, AD_R, 2'(s - 7'd34));
      7'd38: begin
        u.op = OP_DET;
        u.a0 = AD_S;
        u.b0 = AD_S + 6'd3;
        u.a1 = AD_S + 6'd1;
        u.b1 = AD_S + 6'd2;
      end
      [7'd39:7'd42]: begin
        // adjugate: diagonal entries swap, off-diagonal entries negate
        u.op  = OP_DIV;
        u.dst = AD_INV + {4'b0, k};
        u.a0  = AD_S + {4'b0, diag ? ~k : k};
        u.neg = k[0] ^ k[1];
      end
      [7'd43:7'd46]: u = op_mm(AD_K, AD_NUM, AD_INV, 1'b0, 2'(s - 7'd43));
      [7'd47:7'd48]: u = op_mv(AD_HX, AD_H, AD_XP, 1'(s - 7'd47));
      [7'd49:7'd50]: u = op_ew(OP_SUB, AD_INNOV, AD_Z, AD_HX, 2'(s - 7'd49));
      [7'd51:7'd52]: u = op_mv(AD_CORR, AD_K, AD_INNOV, 1'(s - 7'd51));
      [7'd53:7'd54]: u = op_ew(OP_ADD, AD_X, AD_XP, AD_CORR, 2'(s - 7'd53));
      [7'd55:7'd58]: u = op_mm(AD_KH, AD_K, AD_H, 1'b0, 2'(s - 7'd55));
      [7'd59:7'd62]: begin
        u    = op_ew(OP_SUB, AD_IKH, AD_ZERO, AD_KH, 2'(s - 7'd59));
        u.a0 = ((s == 7'd59) || (s == 7'd62)) ? AD_ONE : AD_ZERO;
      end
      [7'd63:7'd66]: u = op_mm(AD_P, AD_IKH, AD_PP, 1'b0, 2'(s - 7'd63));
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// File: src/kfu_ctrl.sv
// ---------------------------------------------------------------------------
// kfu_ctrl
// Sequencer: walks the microcode, drives datapath phases, handles config
// transfers and the input handshake.
// ---------------------------------------------------------------------------
module kfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  kfu_pkg::status_t status,
  output kfu_pkg::cmd_t    cmd
);

  kfu_pkg::state_t state, state_next;
  kfu_pkg::step_t  step, step_next;
  logic [3:0]      cnt, cnt_next;
  kfu_pkg::uop_t   uop;
  logic            last;

  assign uop  = kfu_pkg::ucode(step);
  assign last = (step == kfu_pkg::STEP_LAST);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfu_pkg::S_IDLE;
      step  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    unique case (state)
      kfu_pkg::S_IDLE: begin
        if (cfg_valid) begin
          state_next = kfu_pkg::S_CFG;
          cnt_next   = '0;
        end else if (in_valid) begin
          state_next = kfu_pkg::S_ISSUE;
          step_next  = '0;
        end
      end
      kfu_pkg::S_CFG: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd3) state_next = kfu_pkg::S_IDLE;
      end
      kfu_pkg::S_ISSUE: begin
        unique case (uop.op)
          kfu_pkg::OP_LOAD: begin
            if (last) state_next = kfu_pkg::S_DONE;
            else step_next = step + 7'd1;
          end
          kfu_pkg::OP_MAC, kfu_pkg::OP_DET: state_next = kfu_pkg::S_MUL0;
          kfu_pkg::OP_ADD, kfu_pkg::OP_SUB: state_next = kfu_pkg::S_WB;
          kfu_pkg::OP_DIV: state_next = kfu_pkg::S_DIVI;
          default: state_next = kfu_pkg::S_WB;
        endcase
      end
      kfu_pkg::S_MUL0: state_next = kfu_pkg::S_MUL1;
      kfu_pkg::S_MUL1: state_next = kfu_pkg::S_ACC;
      kfu_pkg::S_ACC:  state_next = kfu_pkg::S_WB;
      kfu_pkg::S_DIVI: begin
        state_next = kfu_pkg::S_DIVS;
        cnt_next   = '0;
      end
      kfu_pkg::S_DIVS: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'(kfu_pkg::DIV_STEPS - 1)) state_next = kfu_pkg::S_WB;
      end
      kfu_pkg::S_WB: begin
        if ((uop.op == kfu_pkg::OP_DET && status.det_zero) || last) begin
          state_next = kfu_pkg::S_DONE;
        end else begin
          state_next = kfu_pkg::S_ISSUE;
          step_next  = step + 7'd1;
        end
      end
      kfu_pkg::S_DONE: begin
        if (status.out_free) state_next = kfu_pkg::S_IDLE;
      end
      default: state_next = kfu_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd           = '0;
    cmd.uop       = uop;
    cmd.cnt       = cnt;
    cfg_ready     = (state == kfu_pkg::S_IDLE);
    in_stall      = (state != kfu_pkg::S_IDLE) || cfg_valid;
    cmd.cfg_take  = (state == kfu_pkg::S_IDLE) && cfg_valid;
    cmd.in_take   = (state == kfu_pkg::S_IDLE) && in_valid && !cfg_valid;
    cmd.cfg_wr    = (state == kfu_pkg::S_CFG);
    cmd.load      = (state == kfu_pkg::S_ISSUE) && (uop.op == kfu_pkg::OP_LOAD);
    cmd.rd_second = (state == kfu_pkg::S_MUL0);
    cmd.mul       = (state == kfu_pkg::S_MUL0) || (state == kfu_pkg::S_MUL1);
    cmd.acc_init  = (state == kfu_pkg::S_MUL1);
    cmd.acc_add   = (state == kfu_pkg::S_ACC);
    cmd.wb        = (state == kfu_pkg::S_WB);
    cmd.div_init  = (state == kfu_pkg::S_DIVI);
    cmd.div_step  = (state == kfu_pkg::S_DIVS);
    cmd.out_load  = (state == kfu_pkg::S_DONE) && status.out_free;
  end

endmodule

// File: src/kfu_dp.sv
// ---------------------------------------------------------------------------
// kfu_dp
// Datapath: scratch memory, shared 16x16 multiplier with accumulator,
// saturating adder, serial divider and output register.
// ---------------------------------------------------------------------------
module kfu_dp (
  input  logic                clk,
  input  logic                rst,
  input  kfu_pkg::cmd_t       cmd,
  output kfu_pkg::status_t    status,
  input  logic signed [15:0]  control_0,
  input  logic signed [15:0]  control_1,
  input  logic signed [15:0]  measure_0,
  input  logic signed [15:0]  measure_1,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  estimate_0,
  output logic signed [15:0]  estimate_1,
  output logic                singular
);

  logic [15:0]        mem [64];
  logic [63:0]        vld;
  logic [15:0]        in_word [4];
  logic [2:0]         cfg_idx;
  logic [63:0]        cfg_val;
  logic [15:0]        rd_mem_a, rd_mem_b;
  logic               rd_vld_a, rd_vld_b;
  kfu_pkg::addr_t     rd_addr_a, rd_addr_b;
  kfu_pkg::addr_t     ra, rb;
  logic signed [15:0] rd_a, rd_b;
  logic signed [31:0] prod;
  logic signed [32:0] acc;
  logic [35:0]        rem;
  logic [51:0]        dsh;
  logic [14:0]        quo;
  logic               ovf, dneg;
  logic               sing;
  logic [15:0]        est0, est1;
  logic               wr_en;
  kfu_pkg::addr_t     wr_addr;
  logic [15:0]        wr_data;
  logic [15:0]        rnd_word, ew_word, div_word;
  logic signed [33:0] rnd_sum, rnd_sh;
  logic signed [16:0] ew_sum;
  logic signed [16:0] adj;
  logic [16:0]        adj_mag;
  logic [32:0]        det_mag;
  logic [35:0]        div_n;
  logic [35:0]        div_d;

  function automatic logic [15:0] sat16(logic signed [33:0] v);
    if (v > 34'sd32767) return 16'h7fff;
    if (v < -34'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] reset_word(kfu_pkg::addr_t a);
    if (a == kfu_pkg::AD_K || a == kfu_pkg::AD_K + 6'd3 || a == kfu_pkg::AD_ONE)
      return kfu_pkg::ONE_Q;
    return 16'h0000;
  endfunction

  // Input and config capture
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      in_word[0] <= control_0;
      in_word[1] <= control_1;
      in_word[2] <= measure_0;
      in_word[3] <= measure_1;
    end
    if (cmd.cfg_take) begin
      cfg_idx <= cfg_index;
      cfg_val <= cfg_data;
    end
  end

  // Scratch memory, two registered read ports; unwritten words read as reset value
  assign ra = cmd.rd_second ? cmd.uop.a1 : cmd.uop.a0;
  assign rb = cmd.rd_second ? cmd.uop.b1 : cmd.uop.b0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_mem_a  <= mem[ra];
    rd_mem_b  <= mem[rb];
    rd_addr_a <= ra;
    rd_addr_b <= rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_a <= 1'b0;
      rd_vld_b <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      rd_vld_a <= vld[ra];
      rd_vld_b <= vld[rb];
    end
  end

  assign rd_a = rd_vld_a ? rd_mem_a : reset_word(rd_addr_a);
  assign rd_b = rd_vld_b ? rd_mem_b : reset_word(rd_addr_b);

  // Multiplier and accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= rd_a * rd_b;
    if (cmd.acc_init) acc <= 33'(prod);
    else if (cmd.acc_add) begin
      if (cmd.uop.op == kfu_pkg::OP_DET) acc <= acc - 33'(prod);
      else acc <= acc + 33'(prod);
    end
  end

  // Round half up by the fraction width, then saturate
  assign rnd_sum  = 34'(acc) + (34'sd1 <<< (kfu_pkg::FRAC_BITS - 1));
  assign rnd_sh   = rnd_sum >>> kfu_pkg::FRAC_BITS;
  assign rnd_word = sat16(rnd_sh);

  // Element-wise add or subtract
  assign ew_sum  = (cmd.uop.op == kfu_pkg::OP_SUB) ? 17'(rd_a) - 17'(rd_b)
                                                   : 17'(rd_a) + 17'(rd_b);
  assign ew_word = sat16(34'(ew_sum));

  // Divider setup: q = (2n + d) / (2d), n = |adj| * 2^(2*FRAC_BITS), d = |det|
  assign adj     = cmd.uop.neg ? -17'(rd_a) : 17'(rd_a);
  assign adj_mag = adj[16] ? 17'(-adj) : adj;
  assign det_mag = acc[32] ? 33'(-acc) : 33'(acc);
  assign div_n   = (36'(adj_mag) << (2 * kfu_pkg::FRAC_BITS + 1)) + {3'b0, det_mag};
  assign div_d   = {2'b0, det_mag, 1'b0};

  // Restoring divider, one quotient bit per cycle; large quotients clamp
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= div_n;
      dsh  <= {2'b0, div_d, 14'b0};
      ovf  <= {16'b0, div_n} >= {1'b0, div_d, 15'b0};
      dneg <= adj[16] ^ acc[32];
      quo  <= '0;
    end else if (cmd.div_step) begin
      if ({16'b0, rem} >= dsh) begin
        rem <= rem - dsh[35:0];
        quo <= {quo[13:0], 1'b1};
      end else begin
        quo <= {quo[13:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign div_word = ovf  ? (dneg ? 16'h8000 : 16'h7fff)
                  : dneg ? 16'(-{1'b0, quo}) : {1'b0, quo};

  // Memory write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd.uop.dst;
    wr_data = rnd_word;
    if (cmd.cfg_wr) begin
      wr_en   = (cfg_idx < 3'(kfu_pkg::NUM_CFG));
      wr_addr = {1'b0, cfg_idx, cmd.cnt[1:0]};
      wr_data = 16'(cfg_val >> {cmd.cnt[1:0], 4'b0});
    end else if (cmd.load) begin
      wr_en   = 1'b1;
      wr_data = in_word[cmd.uop.a0[1:0]];
    end else if (cmd.wb) begin
      case (cmd.uop.op)
        kfu_pkg::OP_MAC: begin
          wr_en   = 1'b1;
          wr_data = rnd_word;
        end
        kfu_pkg::OP_ADD, kfu_pkg::OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = ew_word;
        end
        kfu_pkg::OP_DIV: begin
          wr_en   = 1'b1;
          wr_data = div_word;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Estimate shadow and singular flag
  always_ff @(posedge clk) begin
    if (rst) begin
      est0 <= '0;
      est1 <= '0;
      sing <= 1'b0;
    end else begin
      if (wr_en && wr_addr == kfu_pkg::AD_X) est0 <= wr_data;
      if (wr_en && wr_addr == kfu_pkg::AD_X + 6'd1) est1 <= wr_data;
      if (cmd.wb && cmd.uop.op == kfu_pkg::OP_DET) sing <= (acc == '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      estimate_0 <= est0;
      estimate_1 <= est1;
      singular   <= sing;
    end
  end

  assign status.det_zero = (acc == '0);
  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: src/kalman_filter_update_core.sv
// ---------------------------------------------------------------------------
// kalman_filter_update_core
// Two-state linear Kalman filter step in signed Q8.8 with saturation.
// ---------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) loads A, B, H,
//   Q, R as four Q8.8 words each; a transfer is taken only while idle and
//   then writes the words into scratch memory.
//   Input channel (in_valid/in_stall) carries u and z. One item is in work
//   at a time; in_stall is high from acceptance until the result has been
//   moved into the output register.
//   Output channel (out_valid/out_stall) carries the posterior estimate and
//   the singular flag. The output register holds while stalled; the core
//   waits in its final state until the register is free.
//   Work per item: 40 dot products on the one shared multiplier plus the
//   determinant, 4 inverse entries in the serial divider and 18 adds; a
//   singular item ends after the determinant.
//   Reset: all matrices, x and P clear to zero, the gain to identity.
// ---------------------------------------------------------------------------
module kalman_filter_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] control_0,
  input  logic signed [15:0] control_1,
  input  logic signed [15:0] measure_0,
  input  logic signed [15:0] measure_1,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] estimate_0,
  output logic signed [15:0] estimate_1,
  output logic               singular,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  kfu_pkg::cmd_t    cmd;
  kfu_pkg::status_t status;

  // Sequencer
  kfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  kfu_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .control_0  (control_0),
    .control_1  (control_1),
    .measure_0  (measure_0),
    .measure_1  (measure_1),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .estimate_0 (estimate_0),
    .estimate_1 (estimate_1),
    .singular   (singular)
  );

endmodule
